/* design/lpfs_pkg.sv */
// Package for the length-prefixed frame splitter.
// Holds the phase type, the result word type and the fixed constants.
// No dependencies.
package lpfs_pkg;

    localparam logic [23:0] MAX_LEN_RESET = 24'(1024 * 256);
    localparam logic [31:0] COMMAND_ADDR  = 32'hFFFF_FFFF;
    localparam logic [23:0] MIN_LEN       = 24'd4;

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_ADDRESS,
        PH_PAYLOAD,
        PH_DEAD
    } phase_t;

    typedef struct packed {
        logic       length_error;
        logic       first_of_frame;
        logic       is_command;
        logic       has_byte;
        logic       last_of_frame;
        logic [7:0] out_byte;
    } result_t;

endpackage

/* design/length_prefixed_frame_splitter_core.sv */
// Top level of the length-prefixed frame splitter.
// Depends on lpfs_pkg for the phase type, the result word type and constants.
//
// Usage: received bytes enter on the s_ side, one byte per word. Each frame is
// a 4-byte little-endian length L, a 4-byte address and L-4 payload bytes.
// Result words leave on the m_ side: the byte in m_tdata, the flags in m_tuser
// and the end of a frame on m_tlast. An address of all ones marks a command
// frame, whose address is dropped; otherwise the four address bytes are sent
// ahead of the payload. A length below 4 or above max_frame_len gives one
// error word, after which every input byte is swallowed until reset.
// max_frame_len is written through the cfg_ channel, which is always ready.
// Each accepted byte is decoded in the cycle it is taken and its results are
// written into an output queue of FIFO_DEPTH words; a result reaches the m_
// side from that registered queue. The queue drains one word per cycle while
// m_tready is high. s_tready stays high while at least four entries are free,
// which is the most one byte (the last address byte of a frame) produces.
// A byte can therefore be taken every cycle while the receiver keeps up.
// When the receiver stalls, the queue fills and s_tready drops; no word is
// lost. Reset empties the queue and returns to waiting for a length field.
module length_prefixed_frame_splitter_core #(
    parameter int FIFO_DEPTH = 8    // power of two, at least 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration: max_frame_len
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [23:0]                      cfg_data,
    // Input stream. tdata: [7:0] rx_byte
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,
    // Output stream. tdata: [7:0] out_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,
    // tuser: [0] has_byte, [1] is_command, [2] first_of_frame, [3] length_error
    output logic [3:0]                       m_tuser,
    output logic                             m_tlast
);
    import lpfs_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    // Frame decoder state.
    phase_t      phase_reg, phase_next;
    logic [1:0]  fcount_reg, fcount_next;
    logic [23:0] len_reg, len_next;
    logic [23:0] addr_reg, addr_next;
    logic [23:0] left_reg, left_next;
    logic        cmd_reg, cmd_next;
    logic        first_reg, first_next;
    logic [23:0] max_len_reg;

    // Output queue.
    result_t            mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    logic               in_fire, out_fire;
    logic [2:0]         n_push;
    result_t            push_data [4];
    logic [31:0]        full_addr;
    logic [23:0]        left_dec;
    result_t            head;

    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg <= CNT_W'(FIFO_DEPTH - 4));
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = (count_reg != '0);
    assign out_fire  = m_tvalid && m_tready;

    assign full_addr = {s_tdata, addr_reg};
    assign left_dec  = left_reg - 24'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LENGTH;
            fcount_reg <= '0;
            len_reg    <= '0;
            addr_reg   <= '0;
            left_reg   <= '0;
            cmd_reg    <= 1'b0;
            first_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fcount_reg <= fcount_next;
            len_reg    <= len_next;
            addr_reg   <= addr_next;
            left_reg   <= left_next;
            cmd_reg    <= cmd_next;
            first_reg  <= first_next;
        end
    end

    // Decode one byte: next state and the results it pushes.
    always_comb
    begin
        phase_next  = phase_reg;
        fcount_next = fcount_reg;
        len_next    = len_reg;
        addr_next   = addr_reg;
        left_next   = left_reg;
        cmd_next    = cmd_reg;
        first_next  = first_reg;
        n_push      = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            push_data[i] = '0;
        end

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_LENGTH:
                begin
                    fcount_next = fcount_reg + 2'd1;
                    case (fcount_reg)
                        2'd0:    len_next[7:0]   = s_tdata;
                        2'd1:    len_next[15:8]  = s_tdata;
                        2'd2:    len_next[23:16] = s_tdata;
                        default:
                        begin
                            // Top length byte: any set bit exceeds the 24-bit maximum.
                            if ((s_tdata != 8'd0) || (len_reg < MIN_LEN)
                                || (len_reg > max_len_reg))
                            begin
                                n_push                    = 3'd1;
                                push_data[0].length_error = 1'b1;
                                phase_next                = PH_DEAD;
                            end
                            else
                            begin
                                left_next  = len_reg - MIN_LEN;
                                phase_next = PH_ADDRESS;
                            end
                        end
                    endcase
                end
                PH_ADDRESS:
                begin
                    fcount_next = fcount_reg + 2'd1;
                    case (fcount_reg)
                        2'd0:    addr_next[7:0]   = s_tdata;
                        2'd1:    addr_next[15:8]  = s_tdata;
                        2'd2:    addr_next[23:16] = s_tdata;
                        default:
                        begin
                            if (full_addr == COMMAND_ADDR)
                            begin
                                cmd_next = 1'b1;
                                if (left_reg == '0)
                                begin
                                    // Empty command frame: a single word with no byte.
                                    n_push                      = 3'd1;
                                    push_data[0].is_command     = 1'b1;
                                    push_data[0].first_of_frame = 1'b1;
                                    push_data[0].last_of_frame  = 1'b1;
                                    phase_next                  = PH_LENGTH;
                                end
                                else
                                begin
                                    first_next = 1'b1;
                                    phase_next = PH_PAYLOAD;
                                end
                            end
                            else
                            begin
                                cmd_next   = 1'b0;
                                first_next = 1'b0;
                                n_push     = 3'd4;
                                for (int i = 0; i < 4; i++)
                                begin
                                    push_data[i].out_byte       = full_addr[8*i +: 8];
                                    push_data[i].has_byte       = 1'b1;
                                    push_data[i].first_of_frame = (i == 0);
                                    push_data[i].last_of_frame  =
                                        (i == 3) && (left_reg == '0);
                                end
                                phase_next = (left_reg == '0) ? PH_LENGTH : PH_PAYLOAD;
                            end
                        end
                    endcase
                end
                PH_PAYLOAD:
                begin
                    left_next                   = left_dec;
                    n_push                      = 3'd1;
                    push_data[0].out_byte       = s_tdata;
                    push_data[0].has_byte       = 1'b1;
                    push_data[0].is_command     = cmd_reg;
                    push_data[0].first_of_frame = first_reg;
                    push_data[0].last_of_frame  = (left_dec == '0);
                    first_next                  = 1'b0;
                    if (left_dec == '0)
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_DEAD:
                begin
                    phase_next = PH_DEAD;
                end
                default:
                begin
                    phase_next = PH_DEAD;
                end
            endcase
        end
    end

    // Output queue: up to four words written per cycle, one read.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < n_push)
            begin
                mem[PTR_W'(wr_ptr_reg + PTR_W'(i))] <= push_data[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= PTR_W'(wr_ptr_reg + PTR_W'(n_push));
            if (out_fire)
            begin
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + PTR_W'(1));
            end
            count_reg <= CNT_W'(count_reg + CNT_W'(n_push) - CNT_W'(out_fire));
        end
    end

    assign head     = mem[rd_ptr_reg];
    assign m_tdata  = head.out_byte;
    assign m_tuser  = {head.length_error, head.first_of_frame, head.is_command,
                       head.has_byte};
    assign m_tlast  = head.last_of_frame;

endmodule
